// File: rtl/core/radial_spotlight_luminance_top_assert.svh
// Assertion macros shared by the spotlight RTL files.
// Depends on nothing; the checks compile away when SYNTHESIS is defined.
`ifndef RADIAL_SPOTLIGHT_LUMINANCE_TOP_ASSERT_SVH
`define RADIAL_SPOTLIGHT_LUMINANCE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define RSL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spotlight assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define RSL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spotlight assertion failed");
`else
`define RSL_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RSL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/rsl_pkg.sv
// Package for the radial spotlight luminance block: types and constants.
// Used by every module in rtl/core; depends on nothing.
`timescale 1ns / 1ps

package rsl_pkg;

  // Default parameter values for the top level.
  localparam int DEF_COORD_BITS = 12;
  localparam int DEF_LUM_BITS   = 16;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 1'b1;

  // Distance limit of the lit disc, as a squared distance (160 * 160).
  localparam int FAR_LIMIT_SQ = 25600;
  // Bits of the squared distance that matter inside the disc.
  localparam int NEAR_BITS    = 15;
  // Fraction bits: radicand shift for 8 root fraction bits, and Q1.16 scale.
  localparam int FRAC_SHIFT   = 16;

  // Square root datapath widths.
  localparam int RAD_W  = 32;
  localparam int ROOT_W = 16;
  localparam int REM_W  = 17;

  // Near factor: 65536 - floor((d_q8 * 32 + 12) / 25).
  localparam int TERM_SHIFT   = 5;
  localparam int NEAR_BIAS    = 12;
  localparam int DIV_IN_W     = ROOT_W + TERM_SHIFT;
  // floor(x / 25) = (x * ceil(2^26 / 25)) >> 26 for all x below 2^21.
  localparam int RECIP_W      = 22;
  localparam int RECIP_SHIFT  = 26;
  localparam logic [RECIP_W-1:0] RECIP_25 = 22'd2684355;
  localparam int PROD_W       = DIV_IN_W + RECIP_W;

  // Scale factor, unsigned Q1.16.
  localparam int FACTOR_W = 17;
  localparam logic [FACTOR_W-1:0] ONE_Q16    = 17'h10000;
  localparam logic [FACTOR_W-1:0] FAR_FACTOR = 17'd13107;

  // Control that travels with each pixel down the pipeline.
  typedef struct packed {
    logic valid;
    logic far;
  } rsl_ctrl_t;

  // Partial state of the digit-by-digit square root.
  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } rsl_sqrt_t;

endpackage

// File: rtl/core/radial_spotlight_luminance_top.sv
// Top level of the radial spotlight luminance block.
// Depends on rsl_pkg, rsl_dist, rsl_sqrt_cell and rsl_scale.
//
//   channel  direction  transfer condition      ports
//   input    in         start && !busy          in_pixel_x, in_pixel_y, in_lum_in
//   result   out        out_valid (one cycle)   out_lum_out
//   config   in         cfg_we                  cfg_index, cfg_data
//
// One pixel is taken every cycle while busy is low.
// The pipeline is the 3 front-end stages, one cell per root bit (16) and
// the 4 stages of factor, multiply and rounding.
// Reset is synchronous, active low; busy is high in the cycle after reset.
// Results leave as one-cycle strobes, and the receiver cannot stall them.
`timescale 1ns / 1ps

module radial_spotlight_luminance_top #(
  parameter int COORD_BITS = rsl_pkg::DEF_COORD_BITS,
  parameter int LUM_BITS   = rsl_pkg::DEF_LUM_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [COORD_BITS-1:0]         in_pixel_x,
  input  logic [COORD_BITS-1:0]         in_pixel_y,
  input  logic [LUM_BITS-1:0]           in_lum_in,
  output logic                          out_valid,
  output logic [LUM_BITS-1:0]           out_lum_out,
  input  logic                          cfg_we,
  input  logic [rsl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_BITS:0]           cfg_data
);
  import rsl_pkg::*;

  logic                     busy_r;
  logic                     accept;
  logic signed [COORD_BITS:0] center_x_r;
  logic signed [COORD_BITS:0] center_y_r;
  rsl_ctrl_t                chain_ctrl [0:ROOT_W];
  rsl_sqrt_t                chain_sqrt [0:ROOT_W];
  logic [LUM_BITS-1:0]      chain_lum  [0:ROOT_W];

  // The pipeline takes a pixel every cycle once out of reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // Center registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTER_X: center_x_r <= cfg_data;
        REG_CENTER_Y: center_y_r <= cfg_data;
      endcase
    end
  end

  // Squared distance and disc test.
  rsl_dist #(
    .COORD_BITS (COORD_BITS),
    .LUM_BITS   (LUM_BITS)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (accept),
    .pixel_x  (in_pixel_x),
    .pixel_y  (in_pixel_y),
    .lum      (in_lum_in),
    .center_x (center_x_r),
    .center_y (center_y_r),
    .ctrl_o   (chain_ctrl[0]),
    .sqrt_o   (chain_sqrt[0]),
    .lum_o    (chain_lum[0])
  );

  // Square root chain, one cell per root bit.
  for (genvar k = 0; k < ROOT_W; k++) begin : g_cell
    rsl_sqrt_cell #(
      .LUM_BITS (LUM_BITS)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl_i (chain_ctrl[k]),
      .sqrt_i (chain_sqrt[k]),
      .lum_i  (chain_lum[k]),
      .ctrl_o (chain_ctrl[k+1]),
      .sqrt_o (chain_sqrt[k+1]),
      .lum_o  (chain_lum[k+1])
    );
  end

  // Scale factor and attenuated luminance.
  rsl_scale #(
    .LUM_BITS (LUM_BITS)
  ) u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl_i    (chain_ctrl[ROOT_W]),
    .root_i    (chain_sqrt[ROOT_W].root),
    .lum_i     (chain_lum[ROOT_W]),
    .out_valid (out_valid),
    .out_lum   (out_lum_out)
  );

endmodule

// File: rtl/core/rsl_sqrt_cell.sv
// One cell of the square root chain: settles one root bit per pixel.
// Depends on rsl_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "radial_spotlight_luminance_top_assert.svh"

module rsl_sqrt_cell #(
  parameter int LUM_BITS = rsl_pkg::DEF_LUM_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rsl_pkg::rsl_ctrl_t  ctrl_i,
  input  rsl_pkg::rsl_sqrt_t  sqrt_i,
  input  logic [LUM_BITS-1:0] lum_i,
  output rsl_pkg::rsl_ctrl_t  ctrl_o,
  output rsl_pkg::rsl_sqrt_t  sqrt_o,
  output logic [LUM_BITS-1:0] lum_o
);
  import rsl_pkg::*;

  rsl_ctrl_t           ctrl_r;
  rsl_sqrt_t           sqrt_r;
  rsl_sqrt_t           sqrt_nxt;
  logic [LUM_BITS-1:0] lum_r;
  logic [REM_W+1:0]    cur;
  logic [REM_W+1:0]    trial;

  // Bring down the next two radicand bits and try to subtract 4*root + 1.
  assign cur   = {sqrt_i.rem, sqrt_i.rad[RAD_W-1 -: 2]};
  assign trial = {1'b0, sqrt_i.root, 2'b01};

  always_comb begin
    sqrt_nxt.rad = {sqrt_i.rad[RAD_W-3:0], 2'b00};
    if (cur >= trial) begin
      sqrt_nxt.rem  = REM_W'(cur - trial);
      sqrt_nxt.root = {sqrt_i.root[ROOT_W-2:0], 1'b1};
    end else begin
      sqrt_nxt.rem  = cur[REM_W-1:0];
      sqrt_nxt.root = {sqrt_i.root[ROOT_W-2:0], 1'b0};
    end
  end

  // Control is reset; the datapath carries no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else begin
      ctrl_r <= ctrl_i;
    end
  end

  always_ff @(posedge clk) begin
    sqrt_r <= sqrt_nxt;
    lum_r  <= lum_i;
  end

  assign ctrl_o = ctrl_r;
  assign sqrt_o = sqrt_r;
  assign lum_o  = lum_r;

  // The remainder never exceeds twice the partial root.
  `RSL_ASSERT_IMPL(a_rem_bound, clk, rst_n, ctrl_r.valid, sqrt_r.rem <= {sqrt_r.root, 1'b0})
  // A pixel moves one cell per cycle, never dropped or duplicated.
  `RSL_ASSERT_IMPL(a_valid_moves, clk, rst_n, $past(rst_n), ctrl_r.valid == $past(ctrl_i.valid))

endmodule

// File: rtl/core/rsl_dist.sv
// Front end: offset from the center, squared distance and disc test.
// Depends on rsl_pkg; feeds the first square root cell.
`timescale 1ns / 1ps

module rsl_dist #(
  parameter int COORD_BITS = rsl_pkg::DEF_COORD_BITS,
  parameter int LUM_BITS   = rsl_pkg::DEF_LUM_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [COORD_BITS-1:0]  pixel_x,
  input  logic [COORD_BITS-1:0]  pixel_y,
  input  logic [LUM_BITS-1:0]    lum,
  input  logic signed [COORD_BITS:0] center_x,
  input  logic signed [COORD_BITS:0] center_y,
  output rsl_pkg::rsl_ctrl_t     ctrl_o,
  output rsl_pkg::rsl_sqrt_t     sqrt_o,
  output logic [LUM_BITS-1:0]    lum_o
);
  import rsl_pkg::*;

  localparam int DX_W  = COORD_BITS + 2;
  localparam int SQ_W  = 2 * COORD_BITS + 2;
  localparam int SUM_W = SQ_W + 1;

  logic signed [DX_W-1:0]   px_s, py_s, cx_s, cy_s;
  logic signed [DX_W-1:0]   dx_r, dy_r;
  logic signed [2*DX_W-1:0] sqx_full, sqy_full;
  logic [SQ_W-1:0]          sqx_r, sqy_r;
  logic [SUM_W-1:0]         sum;
  logic                     v1_r, v2_r;
  logic [LUM_BITS-1:0]      lum1_r, lum2_r, lum3_r;
  rsl_ctrl_t                ctrl_r;
  rsl_sqrt_t                sqrt_r;

  // Offsets from the center; the center may lie outside the image.
  assign px_s = $signed({2'b00, pixel_x});
  assign py_s = $signed({2'b00, pixel_y});
  assign cx_s = {center_x[COORD_BITS], center_x};
  assign cy_s = {center_y[COORD_BITS], center_y};

  // Squares of the offsets; both are non-negative and fit SQ_W bits.
  assign sqx_full = dx_r * dx_r;
  assign sqy_full = dy_r * dy_r;

  // Squared distance; only its low bits feed the root inside the disc.
  assign sum = {1'b0, sqx_r} + {1'b0, sqy_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      ctrl_r <= '0;
    end else begin
      v1_r         <= in_valid;
      v2_r         <= v1_r;
      ctrl_r.valid <= v2_r;
      ctrl_r.far   <= sum > SUM_W'(FAR_LIMIT_SQ);
    end
  end

  always_ff @(posedge clk) begin
    dx_r        <= px_s - cx_s;
    dy_r        <= py_s - cy_s;
    sqx_r       <= sqx_full[SQ_W-1:0];
    sqy_r       <= sqy_full[SQ_W-1:0];
    lum1_r      <= lum;
    lum2_r      <= lum1_r;
    lum3_r      <= lum2_r;
    sqrt_r.rad  <= {{(RAD_W-NEAR_BITS-FRAC_SHIFT){1'b0}}, sum[NEAR_BITS-1:0],
                    {FRAC_SHIFT{1'b0}}};
    sqrt_r.rem  <= '0;
    sqrt_r.root <= '0;
  end

  assign ctrl_o = ctrl_r;
  assign sqrt_o = sqrt_r;
  assign lum_o  = lum3_r;

endmodule

// File: rtl/core/rsl_scale.sv
// Back end: scale factor from the distance and the rounded product.
// Depends on rsl_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "radial_spotlight_luminance_top_assert.svh"

module rsl_scale #(
  parameter int LUM_BITS = rsl_pkg::DEF_LUM_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rsl_pkg::rsl_ctrl_t         ctrl_i,
  input  logic [rsl_pkg::ROOT_W-1:0] root_i,
  input  logic [LUM_BITS-1:0]        lum_i,
  output logic                       out_valid,
  output logic [LUM_BITS-1:0]        out_lum
);
  import rsl_pkg::*;

  localparam int P_W = LUM_BITS + FACTOR_W;

  logic [DIV_IN_W-1:0] div_in;
  logic [PROD_W-1:0]   prod_r;
  logic [FACTOR_W-1:0] quot;
  logic [FACTOR_W-1:0] factor_r;
  logic [P_W-1:0]      p_r;
  logic [P_W:0]        rnd;
  rsl_ctrl_t           c1_r, c2_r;
  logic                v3_r, v4_r;
  logic [LUM_BITS-1:0] lum1_r, lum2_r, lum3_r;
  logic [LUM_BITS-1:0] out_lum_r;

  // 0.005 * d in Q16 is d_q8 * 32 / 25, rounded half up.
  assign div_in = {root_i, {TERM_SHIFT{1'b0}}} + DIV_IN_W'(NEAR_BIAS);
  assign quot   = prod_r[RECIP_SHIFT +: FACTOR_W];

  // Round half up, then drop the Q16 fraction.
  assign rnd = {1'b0, p_r} + (P_W+1)'(ONE_Q16 >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      c1_r <= ctrl_i;
      c2_r <= c1_r;
      v3_r <= c2_r.valid;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r    <= PROD_W'(div_in) * PROD_W'(RECIP_25);
    lum1_r    <= lum_i;
    factor_r  <= c1_r.far ? FAR_FACTOR : ONE_Q16 - quot;
    lum2_r    <= lum1_r;
    p_r       <= P_W'(lum2_r) * P_W'(factor_r);
    lum3_r    <= lum2_r;
    out_lum_r <= rnd[FRAC_SHIFT +: LUM_BITS];
  end

  assign out_valid = v4_r;
  assign out_lum   = out_lum_r;

  // The factor stays between 0.2 and 1.
  `RSL_ASSERT_IMPL(a_factor_range, clk, rst_n, c2_r.valid, (factor_r <= ONE_Q16) && (factor_r >= FAR_FACTOR))
  // Outside the disc the factor is exactly the far value.
  `RSL_ASSERT_IMPL(a_far_factor, clk, rst_n, c2_r.valid && c2_r.far, factor_r == FAR_FACTOR)
  // Attenuation never brightens a pixel.
  `RSL_ASSERT_NEXT(a_no_gain, clk, rst_n, v3_r, out_lum_r <= $past(lum3_r))

endmodule
